/* rtl/tpct_pkg.sv */
// ----------------------------------------------------------------------------
// tpct_pkg
// Shared types, codes and constants of the two-phase cubic trajectory core.
// ----------------------------------------------------------------------------
package tpct_pkg;

  localparam int unsigned JointsDefault = 7;
  localparam int unsigned CmdDepth      = 2;
  localparam int unsigned ResDepth      = 2;

  localparam logic [24:0] TimeStepReset   = 25'd33554;
  localparam logic [31:0] ReturnTimeReset = 32'd16777216;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_STRIKE  = 3'd1,
    MODE_RETURN  = 3'd2,
    MODE_REST    = 3'd3,
    MODE_START   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    REG_TIME_STEP   = 2'd0,
    REG_RETURN_TIME = 2'd1,
    REG_ARM_SELECT  = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    CMD_WR_STRIKE,
    CMD_WR_RETURN,
    CMD_WR_REST,
    CMD_TICK_STRIKE,
    CMD_TICK_RETURN,
    CMD_TICK_REST
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [2:0]  joint;
    logic [1:0]  power;
    logic [31:0] data;
    logic        arm;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         slot;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic               moving;
    logic               last;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FETCH,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_ROUND,
    BK_EMIT,
    BK_REST_RD,
    BK_REST_EMIT
  } back_state_e;

endpackage

/* rtl/two_phase_cubic_trajectory_core.sv */
// ----------------------------------------------------------------------------
// two_phase_cubic_trajectory_core
// Per-tick two-phase cubic joint trajectory generator for one arm.
// ----------------------------------------------------------------------------
// A moving tick evaluates each joint in turn: coefficient reads, six Horner
// steps on one shared multiplier (low product, high product, rounding) and an
// emit that waits while the result queue is full; a finishing tick reads and
// emits the rest posture of each joint.
// Reset clears the movement state and the configuration to its defaults;
// coefficient and rest posture memories are undefined until written.
module two_phase_cubic_trajectory_core #(
  parameter int unsigned JOINTS = tpct_pkg::JointsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         mode_i,
  input  logic [2:0]         joint_i,
  input  logic [1:0]         power_index_i,
  input  logic signed [31:0] value_i,
  input  logic [31:0]        hit_time_i,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         joint_slot_o,
  output logic signed [31:0] position_o,
  output logic signed [31:0] velocity_o,
  output logic signed [31:0] acceleration_o,
  output logic               moving_o,
  output logic               last_o
);

  tpct_pkg::cmd_t cmd_in, cmd_out;
  tpct_pkg::res_t res_in, res_out;
  logic           cmd_push, cmd_pop, cmd_empty;
  logic           res_push, res_full;

  tpct_front #(.JOINTS(JOINTS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (push && !full),
    .mode_i        (mode_i),
    .joint_i       (joint_i),
    .power_index_i (power_index_i),
    .value_i       (value_i),
    .hit_time_i    (hit_time_i),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  tpct_fifo #(.Width($bits(tpct_pkg::cmd_t)), .Depth(tpct_pkg::CmdDepth)) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  tpct_back #(.JOINTS(JOINTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  tpct_fifo #(.Width($bits(tpct_pkg::res_t)), .Depth(tpct_pkg::ResDepth)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign joint_slot_o   = res_out.slot;
  assign position_o     = res_out.position;
  assign velocity_o     = res_out.velocity;
  assign acceleration_o = res_out.acceleration;
  assign moving_o       = res_out.moving;
  assign last_o         = res_out.last;

endmodule

/* rtl/tpct_ram.sv */
// ----------------------------------------------------------------------------
// tpct_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpct_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tpct_fifo.sv */
// ----------------------------------------------------------------------------
// tpct_fifo
// Small register-based first-in first-out queue.
// ----------------------------------------------------------------------------
module tpct_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] slot_q [Depth];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/tpct_front.sv */
// ----------------------------------------------------------------------------
// tpct_front
// Accepts input transactions, keeps movement time and configuration, and
// turns load and tick transactions into commands for the evaluation engine.
// ----------------------------------------------------------------------------
module tpct_front #(
  parameter int unsigned JOINTS = tpct_pkg::JointsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               accept_i,
  input  logic [2:0]         mode_i,
  input  logic [2:0]         joint_i,
  input  logic [1:0]         power_index_i,
  input  logic [31:0]        value_i,
  input  logic [31:0]        hit_time_i,
  output logic               cmd_push_o,
  output tpct_pkg::cmd_t     cmd_o
);

  logic [24:0] step_q;
  logic [31:0] ret_q;
  logic        arm_q;
  logic [31:0] elapsed_q, elapsed_d;
  logic [31:0] strike_q, strike_d;
  logic [32:0] hit_end;
  logic [32:0] next_t;
  logic        joint_ok;

  assign hit_end  = {1'b0, strike_q} + {1'b0, ret_q};
  assign next_t   = {1'b0, elapsed_q} + 33'(step_q);
  assign joint_ok = ({2'b00, joint_i} < 5'(JOINTS));

  always_comb begin
    elapsed_d   = elapsed_q;
    strike_d    = strike_q;
    cmd_push_o  = 1'b0;
    cmd_o.kind  = tpct_pkg::CMD_WR_STRIKE;
    cmd_o.joint = joint_i;
    cmd_o.power = power_index_i;
    cmd_o.data  = value_i;
    cmd_o.arm   = arm_q;
    if (accept_i) begin
      unique case (mode_i)
        tpct_pkg::MODE_STRIKE: begin
          cmd_push_o = joint_ok;
          cmd_o.kind = tpct_pkg::CMD_WR_STRIKE;
        end
        tpct_pkg::MODE_RETURN: begin
          cmd_push_o = joint_ok;
          cmd_o.kind = tpct_pkg::CMD_WR_RETURN;
        end
        tpct_pkg::MODE_REST: begin
          cmd_push_o = joint_ok;
          cmd_o.kind = tpct_pkg::CMD_WR_REST;
        end
        tpct_pkg::MODE_START: begin
          elapsed_d = 32'(step_q);
          strike_d  = hit_time_i;
        end
        tpct_pkg::MODE_TICK: begin
          if (elapsed_q != '0) begin
            cmd_push_o = 1'b1;
            elapsed_d  = next_t[32] ? 32'hFFFF_FFFF : next_t[31:0];
            priority if (elapsed_q <= strike_q) begin
              cmd_o.kind = tpct_pkg::CMD_TICK_STRIKE;
              cmd_o.data = elapsed_q;
            end else if ({1'b0, elapsed_q} <= hit_end) begin
              cmd_o.kind = tpct_pkg::CMD_TICK_RETURN;
              cmd_o.data = elapsed_q - strike_q;
            end else begin
              cmd_o.kind = tpct_pkg::CMD_TICK_REST;
              elapsed_d  = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= tpct_pkg::TimeStepReset;
      ret_q     <= tpct_pkg::ReturnTimeReset;
      arm_q     <= 1'b0;
      elapsed_q <= '0;
      strike_q  <= '0;
    end else begin
      elapsed_q <= elapsed_d;
      strike_q  <= strike_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tpct_pkg::REG_TIME_STEP:   step_q <= cfg_wdata_i[24:0];
          tpct_pkg::REG_RETURN_TIME: ret_q  <= cfg_wdata_i;
          tpct_pkg::REG_ARM_SELECT:  arm_q  <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* rtl/tpct_back.sv */
// ----------------------------------------------------------------------------
// tpct_back
// Executes commands: stores coefficients and rest posture, and evaluates the
// cubics of every joint on a moving tick with one shared multiplier.
// ----------------------------------------------------------------------------
module tpct_back #(
  parameter int unsigned JOINTS = tpct_pkg::JointsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  tpct_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output tpct_pkg::res_t res_o
);

  localparam int unsigned JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int unsigned CoefDepth = 2 ** (JW + 3);
  localparam int unsigned RestDepth = 2 ** JW;

  tpct_pkg::back_state_e state_q, state_d;

  logic               phase_q;
  logic               arm_q;
  logic               rest_q;
  logic [31:0]        t_q;
  logic [JW-1:0]      joint_q;
  logic [2:0]         fcnt_q;
  logic [2:0]         step_q;
  logic signed [31:0] cf_q [4];
  logic signed [35:0] h_q;
  logic signed [68:0] prod_q;
  logic signed [31:0] pos_q, vel_q, acc_q;

  logic               coef_we, rest_we;
  logic [JW+2:0]      coef_waddr, coef_raddr;
  logic [JW-1:0]      rest_waddr;
  logic [31:0]        coef_rdata, rest_rdata;
  logic               last_joint;
  logic               is_tick;

  logic signed [52:0] mul_w;
  logic signed [44:0] rnd_w;
  logic signed [33:0] cop_w;
  logic signed [45:0] sum_w;
  logic signed [31:0] sat_w;
  logic signed [35:0] c3x3_w;
  logic [4:0]         slot_w;

  tpct_ram #(.Width(32), .Depth(CoefDepth)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (cmd_i.data),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  tpct_ram #(.Width(32), .Depth(RestDepth)) u_rest_ram (
    .clk_i   (clk_i),
    .we_i    (rest_we),
    .waddr_i (rest_waddr),
    .wdata_i (cmd_i.data),
    .raddr_i (joint_q),
    .rdata_o (rest_rdata)
  );

  assign last_joint = (joint_q == JW'(JOINTS - 1));
  assign is_tick    = (cmd_i.kind == tpct_pkg::CMD_TICK_STRIKE) ||
                      (cmd_i.kind == tpct_pkg::CMD_TICK_RETURN) ||
                      (cmd_i.kind == tpct_pkg::CMD_TICK_REST);

  assign mul_w  = h_q * $signed({1'b0, (state_q == tpct_pkg::BK_MUL_HI) ?
                                        t_q[31:16] : t_q[15:0]});
  assign rnd_w  = 45'((prod_q + 69'sd8388608) >>> 24);
  assign c3x3_w = 36'(cf_q[0]) + (36'(cf_q[0]) <<< 1);
  assign sum_w  = 46'(rnd_w) + 46'(cop_w);
  assign slot_w = arm_q ? 5'(JOINTS) + 5'(joint_q) : 5'(joint_q);

  always_comb begin
    unique case (step_q)
      3'd0:    cop_w = 34'(cf_q[1]);
      3'd1:    cop_w = 34'(cf_q[2]);
      3'd2:    cop_w = 34'(cf_q[3]);
      3'd4:    cop_w = 34'(cf_q[2]);
      default: cop_w = 34'(cf_q[1]) <<< 1;
    endcase
  end

  always_comb begin
    priority if (sum_w > 46'sd2147483647) begin
      sat_w = 32'sh7FFF_FFFF;
    end else if (sum_w < -46'sd2147483648) begin
      sat_w = 32'sh8000_0000;
    end else begin
      sat_w = sum_w[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpct_pkg::BK_IDLE: begin
        if (!cmd_empty_i && is_tick) begin
          state_d = (cmd_i.kind == tpct_pkg::CMD_TICK_REST) ?
                    tpct_pkg::BK_REST_RD : tpct_pkg::BK_FETCH;
        end
      end
      tpct_pkg::BK_FETCH:  if (fcnt_q == 3'd4) state_d = tpct_pkg::BK_MUL_LO;
      tpct_pkg::BK_MUL_LO: state_d = tpct_pkg::BK_MUL_HI;
      tpct_pkg::BK_MUL_HI: state_d = tpct_pkg::BK_ROUND;
      tpct_pkg::BK_ROUND: begin
        state_d = (step_q == 3'd5) ? tpct_pkg::BK_EMIT : tpct_pkg::BK_MUL_LO;
      end
      tpct_pkg::BK_EMIT: begin
        if (!res_full_i) begin
          state_d = last_joint ? tpct_pkg::BK_IDLE : tpct_pkg::BK_FETCH;
        end
      end
      tpct_pkg::BK_REST_RD: state_d = tpct_pkg::BK_REST_EMIT;
      tpct_pkg::BK_REST_EMIT: begin
        if (!res_full_i) begin
          state_d = last_joint ? tpct_pkg::BK_IDLE : tpct_pkg::BK_REST_RD;
        end
      end
      default: state_d = tpct_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = (state_q == tpct_pkg::BK_IDLE) && !cmd_empty_i;
    coef_we    = cmd_pop_o && ((cmd_i.kind == tpct_pkg::CMD_WR_STRIKE) ||
                               (cmd_i.kind == tpct_pkg::CMD_WR_RETURN));
    rest_we    = cmd_pop_o && (cmd_i.kind == tpct_pkg::CMD_WR_REST);
    coef_waddr = {cmd_i.kind == tpct_pkg::CMD_WR_RETURN, JW'(cmd_i.joint), cmd_i.power};
    rest_waddr = JW'(cmd_i.joint);
    coef_raddr = {phase_q, joint_q, fcnt_q[1:0]};
    res_push_o = !res_full_i && ((state_q == tpct_pkg::BK_EMIT) ||
                                 (state_q == tpct_pkg::BK_REST_EMIT));
    res_o.slot         = slot_w[3:0];
    res_o.position     = rest_q ? $signed(rest_rdata) : pos_q;
    res_o.velocity     = rest_q ? '0 : vel_q;
    res_o.acceleration = rest_q ? '0 : acc_q;
    res_o.moving       = !rest_q;
    res_o.last         = last_joint;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpct_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tpct_pkg::BK_IDLE: begin
        phase_q <= (cmd_i.kind == tpct_pkg::CMD_TICK_RETURN);
        rest_q  <= (cmd_i.kind == tpct_pkg::CMD_TICK_REST);
        arm_q   <= cmd_i.arm;
        t_q     <= cmd_i.data;
        joint_q <= '0;
        fcnt_q  <= '0;
      end
      tpct_pkg::BK_FETCH: begin
        if (fcnt_q != 3'd0) begin
          cf_q[2'(fcnt_q - 3'd1)] <= $signed(coef_rdata);
        end
        fcnt_q <= fcnt_q + 3'd1;
        step_q <= '0;
        h_q    <= 36'(cf_q[0]);
      end
      tpct_pkg::BK_MUL_LO: prod_q <= 69'(mul_w);
      tpct_pkg::BK_MUL_HI: prod_q <= prod_q + (69'(mul_w) <<< 16);
      tpct_pkg::BK_ROUND: begin
        step_q <= step_q + 3'd1;
        unique case (step_q)
          3'd2:    h_q <= c3x3_w;
          3'd4:    h_q <= c3x3_w <<< 1;
          default: h_q <= 36'(sat_w);
        endcase
        if (step_q == 3'd2) pos_q <= sat_w;
        if (step_q == 3'd4) vel_q <= sat_w;
        if (step_q == 3'd5) acc_q <= sat_w;
      end
      tpct_pkg::BK_EMIT, tpct_pkg::BK_REST_EMIT: begin
        if (!res_full_i) begin
          joint_q <= joint_q + 1'b1;
          fcnt_q  <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sim/tb_two_phase_cubic_trajectory_core.sv */
// ----------------------------------------------------------------------------
// tb_two_phase_cubic_trajectory_core
// Self-checking testbench of the two-phase cubic trajectory core.
// ----------------------------------------------------------------------------
// The coefficient and rest posture stores are loaded first. A short directed
// table then covers saturation, restarts, all three phases, ignored writes and
// unused modes. Random movements follow under three idling patterns. Every
// result is checked against a cycle-free trajectory predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_two_phase_cubic_trajectory_core;

  localparam int NJ = 7;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam logic [2:0] JOINT_BAD = 3'd7;
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] STEP_MAX = 32'h0100_0000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  joint;
    logic [1:0]  pw;
    logic [31:0] value;
    logic [31:0] hit;
  } cmd_item_t;

  typedef struct {
    logic           is_cfg;
    tpct_pkg::reg_e idx;
    logic [31:0]    cfg_data;
    cmd_item_t      item;
    logic           rest_chk;
    logic [31:0]    rest_pos;
  } row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic push, full, empty, pop;
  logic [2:0] mode_i, joint_i;
  logic [1:0] power_index_i;
  logic signed [31:0] value_i;
  logic [31:0] hit_time_i;
  logic [3:0] joint_slot_o;
  logic signed [31:0] position_o, velocity_o, acceleration_o;
  logic moving_o, last_o;

  two_phase_cubic_trajectory_core dut (.*);

  // Predictor state.
  logic [31:0] pr_step, pr_ret, pr_t, pr_hit;
  logic        pr_arm;
  logic signed [31:0] strike_c [NJ][4];
  logic signed [31:0] return_c [NJ][4];
  logic signed [31:0] rest_c   [NJ];

  tpct_pkg::res_t trajectory_q[$];
  row_t directed_rows[$];
  tpct_pkg::res_t want;

  int send_idle_pct, recv_idle_pct;
  int errors, mismatches, items_sent, results_seen, motions, rest_ticks;
  logic hold, hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("** two_phase_cubic_trajectory_core: FAILED **");
    $finish;
  end

  function automatic logic signed [79:0] horner_step(logic signed [79:0] acc,
                                                     logic [31:0] t,
                                                     logic signed [79:0] c);
    logic signed [79:0] p;
    p = acc * $signed({48'd0, t});
    p = ((p + (80'sd1 <<< 23)) >>> 24) + c;
    if (p > $signed({48'd0, Q_MAX})) p = $signed({48'd0, Q_MAX});
    if (p < -$signed({48'd0, Q_MIN})) p = -$signed({48'd0, Q_MIN});
    return p;
  endfunction

  task automatic eval_joint(input logic signed [31:0] c [4], input logic [31:0] t,
                            output logic [31:0] p, output logic [31:0] v,
                            output logic [31:0] a);
    logic signed [79:0] acc, c0, c1, c2, c3;
    c0 = c[0];
    c1 = c[1];
    c2 = c[2];
    c3 = c[3];
    acc = horner_step(c0, t, c1);
    acc = horner_step(acc, t, c2);
    acc = horner_step(acc, t, c3);
    p = acc[31:0];
    acc = horner_step(3 * c0, t, 2 * c1);
    acc = horner_step(acc, t, c2);
    v = acc[31:0];
    acc = horner_step(6 * c0, t, 2 * c1);
    a = acc[31:0];
  endtask

  task automatic model_item(input cmd_item_t it);
    logic [32:0] hit_end, nt;
    logic [31:0] p, v, a;
    int phase;
    tpct_pkg::res_t r;
    if (it.mode inside {tpct_pkg::MODE_STRIKE, tpct_pkg::MODE_RETURN,
                        tpct_pkg::MODE_REST}) begin
      if (it.joint < NJ) begin
        case (it.mode)
          tpct_pkg::MODE_STRIKE: strike_c[it.joint][it.pw] = it.value;
          tpct_pkg::MODE_RETURN: return_c[it.joint][it.pw] = it.value;
          default:               rest_c[it.joint] = it.value;
        endcase
      end
    end else if (it.mode == tpct_pkg::MODE_START) begin
      pr_t = pr_step;
      pr_hit = it.hit;
    end else if (it.mode == tpct_pkg::MODE_TICK && pr_t != 0) begin
      hit_end = {1'b0, pr_hit} + {1'b0, pr_ret};
      phase = (pr_t <= pr_hit) ? 0 : ({1'b0, pr_t} <= hit_end) ? 1 : 2;
      for (int j = 0; j < NJ; j++) begin
        if (phase == 0) eval_joint(strike_c[j], pr_t, p, v, a);
        else if (phase == 1) eval_joint(return_c[j], pr_t - pr_hit, p, v, a);
        else begin
          p = rest_c[j];
          v = '0;
          a = '0;
        end
        r.slot = 4'(pr_arm * NJ + j);
        r.position = p;
        r.velocity = v;
        r.acceleration = a;
        r.moving = (phase != 2);
        r.last = (j == NJ - 1);
        trajectory_q.push_back(r);
      end
      if (phase == 2) begin
        pr_t = '0;
        rest_ticks++;
      end else begin
        nt = {1'b0, pr_t} + {1'b0, pr_step};
        pr_t = nt[32] ? 32'hffff_ffff : nt[31:0];
      end
    end
  endtask

  task automatic send_item(input cmd_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    mode_i <= it.mode;
    joint_i <= it.joint;
    power_index_i <= it.pw;
    value_i <= it.value;
    hit_time_i <= it.hit;
    do @(posedge clk_i); while (full);
    model_item(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (trajectory_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input tpct_pkg::reg_e idx, input logic [31:0] data);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tpct_pkg::REG_TIME_STEP:   pr_step = {7'd0, data[24:0]};
      tpct_pkg::REG_RETURN_TIME: pr_ret = data;
      default:                   pr_arm = data[0];
    endcase
  endtask

  function automatic cmd_item_t mk(logic [2:0] mode, logic [2:0] joint, logic [1:0] pw,
                                   logic [31:0] value, logic [31:0] hit);
    cmd_item_t it;
    it.mode = mode;
    it.joint = joint;
    it.pw = pw;
    it.value = value;
    it.hit = hit;
    return it;
  endfunction

  task automatic add_cmd(input cmd_item_t it, input logic rest_chk = 1'b0,
                         input logic [31:0] rest_pos = '0);
    row_t r;
    r.is_cfg = 1'b0;
    r.idx = tpct_pkg::REG_TIME_STEP;
    r.cfg_data = '0;
    r.item = it;
    r.rest_chk = rest_chk;
    r.rest_pos = rest_pos;
    directed_rows.push_back(r);
  endtask

  task automatic add_cfg(input tpct_pkg::reg_e idx, input logic [31:0] data);
    row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.cfg_data = data;
    r.item = '0;
    r.rest_chk = 1'b0;
    r.rest_pos = '0;
    directed_rows.push_back(r);
  endtask

  function automatic logic [31:0] rnd_value();
    logic [31:0] x;
    x = $urandom();
    if ($urandom_range(3) != 0) x = {{13{x[18]}}, x[18:0]};
    return x;
  endfunction

  function automatic logic [31:0] rnd_step();
    case ($urandom_range(5))
      0:       return 32'd1;
      1:       return STEP_MAX;
      default: return $urandom_range(32'h0100_0000, 32'h0040_0000);
    endcase
  endfunction

  task automatic run_motion();
    logic [31:0] hit;
    int k;
    repeat ($urandom_range(8, 2)) begin
      send_item(mk(3'($urandom_range(tpct_pkg::MODE_REST, tpct_pkg::MODE_STRIKE)),
                   ($urandom_range(7) == 0) ? JOINT_BAD : 3'($urandom_range(NJ - 1)),
                   2'($urandom()), rnd_value(), $urandom()));
    end
    if ($urandom_range(3) == 0) begin
      send_item(mk(3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO)), 3'($urandom()),
                   2'($urandom()), $urandom(), $urandom()));
    end
    hit = ($urandom_range(5) == 0) ? $urandom() : $urandom_range(3 * pr_step, 0);
    send_item(mk(tpct_pkg::MODE_START, 3'($urandom()), 2'($urandom()), $urandom(), hit));
    k = 0;
    while (pr_t != 0 && k < 10) begin
      send_item(mk(tpct_pkg::MODE_TICK, 3'($urandom()), 2'($urandom()), $urandom(),
                   $urandom()));
      k++;
    end
    motions++;
  endtask

  task automatic random_config();
    write_reg(tpct_pkg::REG_TIME_STEP, rnd_step());
    case ($urandom_range(3))
      0:       write_reg(tpct_pkg::REG_RETURN_TIME, '0);
      1:       write_reg(tpct_pkg::REG_RETURN_TIME, 32'hffff_ffff);
      default: write_reg(tpct_pkg::REG_RETURN_TIME, $urandom_range(4 * pr_step, 0));
    endcase
    write_reg(tpct_pkg::REG_ARM_SELECT, 32'($urandom_range(1)));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        results_seen++;
        if (trajectory_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("Unexpected result: slot %0d", joint_slot_o);
        end else begin
          want = trajectory_q.pop_front();
          if (joint_slot_o !== want.slot || position_o !== want.position
              || velocity_o !== want.velocity || acceleration_o !== want.acceleration
              || moving_o !== want.moving || last_o !== want.last) begin
            errors++;
            if (mismatches++ < 10) begin
              $display("Mismatch: expected slot %0d p %h v %h a %h mv %b l %b",
                       want.slot, want.position, want.velocity, want.acceleration,
                       want.moving, want.last);
              $display("          actual   slot %0d p %h v %h a %h mv %b l %b",
                       joint_slot_o, position_o, velocity_o, acceleration_o,
                       moving_o, last_o);
            end
          end
        end
      end
      pop <= !hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    wait (hold_req);
    hold <= 1'b1;
    repeat (1500) @(posedge clk_i);
    hold <= 1'b0;
  end

  initial begin
    int n;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    push = 1'b0;
    pop = 1'b0;
    mode_i = '0;
    joint_i = '0;
    power_index_i = '0;
    value_i = '0;
    hit_time_i = '0;
    hold = 1'b0;
    hold_req = 1'b0;
    errors = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    motions = 0;
    rest_ticks = 0;
    pr_step = 32'(tpct_pkg::TimeStepReset);
    pr_ret = tpct_pkg::ReturnTimeReset;
    pr_arm = 1'b0;
    pr_t = '0;
    pr_hit = '0;
    send_idle_pct = 12;
    recv_idle_pct = 56;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int j = 0; j < NJ; j++) begin
      for (int k = 0; k < 4; k++) begin
        send_item(mk(tpct_pkg::MODE_STRIKE, 3'(j), 2'(k), rnd_value(), '0));
        send_item(mk(tpct_pkg::MODE_RETURN, 3'(j), 2'(k), rnd_value(), '0));
      end
      send_item(mk(tpct_pkg::MODE_REST, 3'(j), '0, rnd_value(), '0));
    end

    add_cmd(mk(tpct_pkg::MODE_TICK, '0, '0, '0, '0));
    add_cmd(mk(MODE_UNUSED_LO, 3'd7, 2'd3, 32'hffff_ffff, 32'hffff_ffff));
    add_cmd(mk(MODE_UNUSED_HI, '0, '0, '0, '0));
    add_cmd(mk(tpct_pkg::MODE_STRIKE, JOINT_BAD, 2'd3, Q_MAX, '0));
    add_cmd(mk(tpct_pkg::MODE_STRIKE, 3'd0, 2'd0, Q_MAX, '0));
    add_cmd(mk(tpct_pkg::MODE_STRIKE, 3'd0, 2'd1, Q_MIN, '0));
    add_cmd(mk(tpct_pkg::MODE_STRIKE, 3'd0, 2'd2, Q_MAX, '0));
    add_cmd(mk(tpct_pkg::MODE_STRIKE, 3'd0, 2'd3, Q_MIN, '0));
    add_cmd(mk(tpct_pkg::MODE_REST, 3'd0, '0, 32'h1234_5678, '0));
    add_cmd(mk(tpct_pkg::MODE_REST, 3'd6, '0, Q_MIN, '0));
    add_cmd(mk(tpct_pkg::MODE_START, '0, '0, '0, 32'hffff_ffff));
    add_cmd(mk(tpct_pkg::MODE_TICK, '0, '0, '0, '0));
    add_cmd(mk(tpct_pkg::MODE_TICK, '0, '0, '0, '0));
    add_cmd(mk(tpct_pkg::MODE_START, '0, '0, '0, '0));
    add_cmd(mk(tpct_pkg::MODE_TICK, '0, '0, '0, '0));
    add_cmd(mk(tpct_pkg::MODE_RETURN, 3'd6, 2'd3, Q_MAX, '0));
    add_cmd(mk(tpct_pkg::MODE_TICK, '0, '0, '0, '0));
    add_cfg(tpct_pkg::REG_RETURN_TIME, '0);
    add_cfg(tpct_pkg::REG_TIME_STEP, STEP_MAX);
    add_cmd(mk(tpct_pkg::MODE_START, '0, '0, '0, '0));
    add_cmd(mk(tpct_pkg::MODE_TICK, '0, '0, '0, '0), 1'b1, 32'h1234_5678);
    add_cmd(mk(tpct_pkg::MODE_TICK, '0, '0, '0, '0));
    add_cfg(tpct_pkg::REG_ARM_SELECT, 32'd1);
    add_cmd(mk(tpct_pkg::MODE_START, '0, '0, '0, '0));
    add_cmd(mk(tpct_pkg::MODE_TICK, '0, '0, '0, '0), 1'b1, 32'h1234_5678);
    add_cfg(tpct_pkg::REG_TIME_STEP, 32'd1);
    add_cfg(tpct_pkg::REG_RETURN_TIME, 32'hffff_ffff);
    add_cmd(mk(tpct_pkg::MODE_START, '0, '0, '0, '0));
    add_cmd(mk(tpct_pkg::MODE_TICK, '0, '0, '0, '0));
    add_cmd(mk(tpct_pkg::MODE_TICK, '0, '0, '0, '0));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_reg(directed_rows[i].idx, directed_rows[i].cfg_data);
      end else begin
        n = trajectory_q.size();
        send_item(directed_rows[i].item);
        if (directed_rows[i].rest_chk
            && trajectory_q[n].position !== directed_rows[i].rest_pos) begin
          errors++;
          $display("Rest posture prediction differs from the table in row %0d", i);
        end
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 56 : 0;
      recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 12 : 0;
      random_config();
      if (ph == 2) hold_req = 1'b1;
      while (items_sent < 63 + 25 + 35 * (ph + 1)) begin
        run_motion();
        if ($urandom_range(3) == 0) random_config();
        if ($urandom_range(5) == 0) wait_drained();
      end
    end

    push <= 1'b0;
    while (trajectory_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES * 4) @(posedge clk_i);

    $display("Covered %0d transactions in %0d movements, %0d results, %0d rest ticks.",
             items_sent, motions, results_seen, rest_ticks);
    $display("Saturating coefficients, restarts, ignored writes and both arms were used.");
    if (errors == 0 && trajectory_q.size() == 0) begin
      $display("** two_phase_cubic_trajectory_core: PASSED **");
    end else begin
      $display("%0d errors, %0d results outstanding", errors, trajectory_q.size());
      $display("** two_phase_cubic_trajectory_core: FAILED **");
    end
    $finish;
  end

endmodule
